>>> rtl/core/nsc_pkg.sv
package nsc_pkg;

  // default longest sentence body
  localparam int MAX_BODY_DEFAULT = 255;

  // result kinds
  localparam logic [2:0] KIND_BODY     = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_MISMATCH = 3'd2;
  localparam logic [2:0] KIND_BAD_CHAR = 3'd3;
  localparam logic [2:0] KIND_BAD_HEX  = 3'd4;
  localparam logic [2:0] KIND_TOO_LONG = 3'd5;

  // special characters
  localparam logic [6:0] CHAR_START = 7'h24;
  localparam logic [6:0] CHAR_END   = 7'h2a;
  localparam logic [6:0] CHAR_DOT   = 7'h2e;
  localparam logic [6:0] CHAR_COMMA = 7'h2c;
  localparam logic [6:0] CHAR_PLUS  = 7'h2b;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_READ,
    PH_CK0,
    PH_CK1
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       block_last;
  } item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] body_byte;
    logic [7:0] sentence_length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  // character class of one byte
  typedef struct packed {
    logic       is_content;
    logic       is_start;
    logic       is_end;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_class_t;

endpackage

>>> rtl/core/nsc_classify.sv
module nsc_classify
  import nsc_pkg::*;
(
  input  logic [7:0]  rx_byte,
  output char_class_t cls
);

  logic [6:0] c7;
  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic       is_upper_hex;
  logic       is_lower_hex;
  logic       is_punct;

  assign c7 = rx_byte[6:0];

  // character ranges on the low 7 bits
  assign is_digit     = (c7 >= 7'h30) && (c7 <= 7'h39);
  assign is_upper     = (c7 >= 7'h41) && (c7 <= 7'h5a);
  assign is_lower     = (c7 >= 7'h61) && (c7 <= 7'h7a);
  assign is_upper_hex = (c7 >= 7'h41) && (c7 <= 7'h46);
  assign is_lower_hex = (c7 >= 7'h61) && (c7 <= 7'h66);
  assign is_punct     = (c7 == CHAR_DOT) || (c7 == CHAR_COMMA) ||
                        (c7 == CHAR_PLUS) || (c7 == CHAR_MINUS);

  // class flags and digit value, lower and upper case alike
  always_comb begin
    cls.is_start   = (c7 == CHAR_START);
    cls.is_end     = (c7 == CHAR_END);
    cls.is_hex     = is_digit || is_upper_hex || is_lower_hex;
    cls.is_content = is_digit || is_upper || is_lower || is_punct ||
                     cls.is_start || cls.is_end;
    if (is_digit) begin
      cls.hex_val = c7[3:0];
    end else begin
      cls.hex_val = 4'(c7[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

>>> rtl/core/nsc_engine.sv
module nsc_engine
  import nsc_pkg::*;
#(
  parameter int MAX_BODY = MAX_BODY_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  input  item_t       word,
  input  char_class_t cls,
  output logic        advance,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  localparam int CW = $clog2(MAX_BODY + 1);

  phase_t          phase;
  phase_t          phase_next;
  logic [7:0]      running_xor;
  logic [7:0]      running_xor_next;
  logic [CW-1:0]   body_count;
  logic [CW-1:0]   body_count_next;
  logic [3:0]      high_digit;
  logic [3:0]      high_digit_next;
  logic            emit;
  result_t         result_next;
  logic [7:0]      reported;
  logic            too_long;

  // step when the result slot is free or being emptied
  assign advance  = word_valid && (!result_valid || result_ready);
  assign reported = {high_digit, cls.hex_val};
  assign too_long = (body_count >= CW'(MAX_BODY));

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SEARCH: begin
        if (cls.is_start) phase_next = PH_READ;
      end
      PH_READ: begin
        if (cls.is_end) begin
          phase_next = PH_CK0;
        end else if (!cls.is_content || too_long) begin
          phase_next = PH_SEARCH;
        end
      end
      PH_CK0: begin
        phase_next = cls.is_hex ? PH_CK1 : PH_SEARCH;
      end
      PH_CK1: begin
        phase_next = PH_SEARCH;
      end
      default: phase_next = PH_SEARCH;
    endcase
    if (word.block_last) phase_next = PH_SEARCH;
  end

  // datapath and result for this word
  always_comb begin
    running_xor_next = running_xor;
    body_count_next  = body_count;
    high_digit_next  = high_digit;
    emit             = 1'b0;
    result_next      = '0;
    unique case (phase)
      PH_SEARCH: begin
        if (cls.is_start) begin
          running_xor_next = '0;
          body_count_next  = '0;
        end
      end
      PH_READ: begin
        if (cls.is_end) begin
          emit = 1'b0;
        end else if (!cls.is_content) begin
          emit                    = 1'b1;
          result_next.result_kind = KIND_BAD_CHAR;
        end else if (too_long) begin
          emit                    = 1'b1;
          result_next.result_kind = KIND_TOO_LONG;
        end else begin
          emit                    = 1'b1;
          body_count_next         = body_count + CW'(1);
          running_xor_next        = running_xor ^ word.rx_byte;
          result_next.result_kind = KIND_BODY;
          result_next.body_byte   = word.rx_byte;
        end
      end
      PH_CK0: begin
        if (cls.is_hex) begin
          high_digit_next = cls.hex_val;
        end else begin
          emit                    = 1'b1;
          result_next.result_kind = KIND_BAD_HEX;
        end
      end
      PH_CK1: begin
        emit = 1'b1;
        if (cls.is_hex) begin
          result_next.result_kind  = (reported == running_xor) ?
                                     KIND_GOOD : KIND_MISMATCH;
          result_next.received_sum = reported;
        end else begin
          result_next.result_kind = KIND_BAD_HEX;
        end
      end
      default: emit = 1'b0;
    endcase
    result_next.sentence_length = 8'(body_count_next);
    result_next.computed_sum    = running_xor_next;
  end

  // sentence state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      running_xor <= '0;
      body_count  <= '0;
      high_digit  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      body_count  <= body_count_next;
      high_digit  <= high_digit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/core/nmea_sentence_checker.sv
// NMEA 0183 sentence checker
// The item channel (item_valid / item_ready / item) takes one received byte
// per word with a block_last flag; the result channel (result_valid /
// result_ready / result) gives at most one result word per byte: a forwarded
// body byte, a good or mismatched checksum report, or an abort code.
// A byte is held in an input register, then classed and stepped through the
// sentence state machine into the result register. One byte per cycle is
// taken in the steady state while the receiver takes each result; the single
// XOR and length counter step set that figure. A byte that gives no result
// still passes through the input register and the state machine.
// When the receiver stalls with a result waiting, the input register holds
// one more byte and then item_ready drops until the result is taken.
// Reset clears both registers' valid flags and returns the checker to
// searching for a start character with a zero checksum and length.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int MAX_BODY = MAX_BODY_DEFAULT
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  item_t       word;
  logic        word_valid;
  logic        advance;
  char_class_t cls;

  assign item_ready = !word_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (item_ready) begin
      word_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      word <= item;
    end
  end

  // character class of the held word
  nsc_classify u_classify (
    .rx_byte (word.rx_byte),
    .cls     (cls)
  );

  // sentence state and result register
  nsc_engine #(
    .MAX_BODY (MAX_BODY)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word         (word),
    .cls          (cls),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
